@@ sv/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types for the text console writer: screen geometry,
// field widths, op codes and the controller state encoding.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  // port field widths
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;
  localparam int OCOL_W = 7;
  localparam int OROW_W = 5;
  localparam int DATA_W = 16;

  // wide enough for a cell index plus the ring base
  localparam int LIN_W = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;

  localparam logic [DATA_W-1:0] BLANK_CELL   = 16'h0720;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_BLANK = 4'b1000
  } state_t;

endpackage

@@ sv/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Text screen of COLUMNS x ROWS cells in one synchronous RAM, used as a ring
// of rows so that a scroll only moves a base pointer and blanks one row.
// ----------------------------------------------------------------------------
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+---------------------
//  command   | in_op in_char_code in_attribute         | start && !busy
//            | in_cell_index                           |
//  result    | out_cursor_col out_cursor_row           | out_valid, 1 cycle
//            | out_cell_data out_scrolled              |
//
//  put: ST_EXEC then the result register; read: ST_EXEC, the registered RAM
//  read in ST_READ, then the result register. put that scrolls: the bottom
//  row is blanked in ST_BLANK one cell a cycle through the single RAM port.
//  clear: the whole RAM is blanked in ST_BLANK, one cell a cycle.
//  after reset the RAM is blanked with busy high.
//  the receiver cannot stall; busy drops in the cycle of the result strobe.
module text_console_writer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [tcw_pkg::OP_W-1:0]    in_op,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tcw_pkg::ATTR_W-1:0]  in_attribute,
  input  logic [tcw_pkg::IDX_W-1:0]   in_cell_index,
  output logic                        out_valid,
  output logic [tcw_pkg::OCOL_W-1:0]  out_cursor_col,
  output logic [tcw_pkg::OROW_W-1:0]  out_cursor_row,
  output logic [tcw_pkg::DATA_W-1:0]  out_cell_data,
  output logic                        out_scrolled
);
  import tcw_pkg::*;

  logic [DATA_W-1:0] mem [CELLS];
  logic [DATA_W-1:0] rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] mem_wdata;

  state_t state_r, state_nxt;

  logic [OP_W-1:0]   op_r;
  logic [CHAR_W-1:0] char_r;
  logic [ATTR_W-1:0] attr_r;
  logic [IDX_W-1:0]  idx_r;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  logic [ADDR_W-1:0] sweep_last_r, sweep_last_nxt;
  logic              report_r, report_nxt;
  logic              scrl_r, scrl_nxt;
  logic              in_range_r, in_range_nxt;

  logic              valid_nxt;
  logic [DATA_W-1:0] data_nxt;

  logic              out_valid_r;
  logic [OCOL_W-1:0] out_col_r;
  logic [OROW_W-1:0] out_row_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_scrl_r;

  logic              accept;
  logic [LIN_W-1:0]  lin;
  logic [LIN_W-1:0]  phys_sum;
  logic [LIN_W-1:0]  phys;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic [ADDR_W:0]   base_inc;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // logical cell to ring address
  always_comb begin
    if (op_r == OP_READ) begin
      lin = LIN_W'(idx_r);
    end else begin
      lin = LIN_W'(row_r) * LIN_W'(COLUMNS) + LIN_W'(col_r);
    end
    phys_sum = lin + LIN_W'(base_r);
    phys     = (phys_sum >= LIN_W'(CELLS)) ? phys_sum - LIN_W'(CELLS) : phys_sum;
  end

  always_comb begin
    state_nxt      = state_r;
    mem_we         = 1'b0;
    mem_addr       = sweep_r;
    mem_wdata      = BLANK_CELL;
    col_nxt        = col_r;
    row_nxt        = row_r;
    base_nxt       = base_r;
    sweep_nxt      = sweep_r;
    sweep_last_nxt = sweep_last_r;
    report_nxt     = report_r;
    scrl_nxt       = scrl_r;
    in_range_nxt   = in_range_r;
    valid_nxt      = 1'b0;
    data_nxt       = '0;
    col_inc        = '0;
    row_inc        = '0;
    base_inc       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        mem_addr = phys[ADDR_W-1:0];
        unique case (op_r)
          OP_PUT: begin
            row_inc = {1'b0, row_r} + 1'b1;
            if (char_r == NEWLINE_CODE) begin
              col_nxt = '0;
              row_nxt = row_inc[ROW_W-1:0];
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {attr_r, char_r};
              col_inc   = {1'b0, col_r} + 1'b1;
              if (col_inc >= (COL_W+1)'(COLUMNS)) begin
                col_nxt = '0;
                row_nxt = row_inc[ROW_W-1:0];
              end else begin
                col_nxt = col_inc[COL_W-1:0];
                row_inc = {1'b0, row_r};
              end
            end
            if (row_inc >= (ROW_W+1)'(ROWS)) begin
              // ring advances one row; the old top row becomes the new bottom
              row_nxt        = ROW_W'(ROWS - 1);
              base_inc       = {1'b0, base_r} + (ADDR_W+1)'(COLUMNS);
              base_nxt       = (base_inc >= (ADDR_W+1)'(CELLS)) ?
                               ADDR_W'(base_inc - (ADDR_W+1)'(CELLS)) :
                               base_inc[ADDR_W-1:0];
              sweep_nxt      = base_r;
              sweep_last_nxt = base_r + ADDR_W'(COLUMNS - 1);
              report_nxt     = 1'b1;
              scrl_nxt       = 1'b1;
              state_nxt      = ST_BLANK;
            end else begin
              valid_nxt = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          OP_CLEAR: begin
            col_nxt        = '0;
            row_nxt        = '0;
            base_nxt       = '0;
            sweep_nxt      = '0;
            sweep_last_nxt = ADDR_W'(CELLS - 1);
            report_nxt     = 1'b1;
            scrl_nxt       = 1'b0;
            state_nxt      = ST_BLANK;
          end
          OP_READ: begin
            in_range_nxt = (LIN_W'(idx_r) < LIN_W'(CELLS));
            state_nxt    = ST_READ;
          end
          default: begin
            valid_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_READ: begin
        valid_nxt = 1'b1;
        data_nxt  = in_range_r ? rdata_r : '0;
        state_nxt = ST_IDLE;
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == sweep_last_r) begin
          valid_nxt  = report_r;
          report_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // blanking pass over the whole RAM after reset
      state_r      <= ST_BLANK;
      col_r        <= '0;
      row_r        <= '0;
      base_r       <= '0;
      sweep_r      <= '0;
      sweep_last_r <= ADDR_W'(CELLS - 1);
      report_r     <= 1'b0;
      scrl_r       <= 1'b0;
      in_range_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      base_r       <= base_nxt;
      sweep_r      <= sweep_nxt;
      sweep_last_r <= sweep_last_nxt;
      report_r     <= report_nxt;
      scrl_r       <= scrl_nxt;
      in_range_r   <= in_range_nxt;
      out_valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      char_r <= in_char_code;
      attr_r <= in_attribute;
      idx_r  <= in_cell_index;
    end
    if (valid_nxt) begin
      out_col_r  <= OCOL_W'(col_nxt);
      out_row_r  <= OROW_W'(row_nxt);
      out_data_r <= data_nxt;
      out_scrl_r <= (state_r == ST_BLANK) ? scrl_r : 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_cell_data  = out_data_r;
  assign out_scrolled   = out_scrl_r;

  // a result transfer only follows a cycle of work
  a_valid_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy))
    else $error("result strobe without preceding work");

  // a scroll always leaves the cursor on the last row
  a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_scrl_r) |-> (row_r == ROW_W'(ROWS - 1)))
    else $error("scroll left cursor off the last row");

  // ring base and cursor stay inside the screen
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (base_r < ADDR_W'(CELLS)) && (col_r < COL_W'(COLUMNS)) &&
    (ROW_W'(row_r) < ROW_W'(ROWS)))
    else $error("cursor or ring base out of range");

  // no new command is taken while a blanking sweep runs
  a_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BLANK) |-> busy)
    else $error("sweep running while idle");

endmodule
